// ----- rtl/core/aobs_pkg.sv -----
package aobs_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Signed container: magnitude never exceeds 2^47 - 1.
    localparam int FXW  = 48;
    localparam int MAGW = 47;

    typedef logic signed [FXW-1:0] t_fx;
    typedef logic [MAGW-1:0]       t_mag;

    localparam t_mag LIM = {MAGW{1'b1}};
    localparam logic signed [FXW:0] LIM_W = {2'b00, LIM};

    // Configuration register indexes.
    localparam logic CFG_ACCEL = 1'b0;
    localparam logic CFG_BRAKE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEG_DISC = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;

    // Register reset values.
    localparam logic signed [31:0] ACCEL_RST = 32'sd65536;
    localparam logic signed [31:0] BRAKE_RST = -32'sd65536;

    // Control flags that travel down a divider chain.
    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
    } t_div_ctl;

    // Clamp a widened sum into the container range.
    function automatic t_fx sat_fx(input logic signed [FXW:0] v);
        logic signed [FXW:0] lo;
        lo = -LIM_W;
        if (v > LIM_W) begin
            return $signed({1'b0, LIM});
        end else if (v < lo) begin
            return -$signed({1'b0, LIM});
        end
        return v[FXW-1:0];
    endfunction

    function automatic t_fx add_fx(input t_fx a, input t_fx b);
        logic signed [FXW:0] s;
        s = {a[FXW-1], a} + {b[FXW-1], b};
        return sat_fx(s);
    endfunction

    function automatic t_fx sub_fx(input t_fx a, input t_fx b);
        logic signed [FXW:0] s;
        s = {a[FXW-1], a} - {b[FXW-1], b};
        return sat_fx(s);
    endfunction

    // Give a magnitude its sign.
    function automatic t_fx from_mag(input t_mag m, input logic neg);
        t_fx v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    // Magnitude of a container value.
    function automatic t_mag mag_fx(input t_fx v);
        t_fx n;
        n = -v;
        return v[FXW-1] ? n[MAGW-1:0] : v[MAGW-1:0];
    endfunction

endpackage

// ----- rtl/core/aobs_div_cell.sv -----
module aobs_div_cell #(
    parameter int BW = 32,
    parameter int NW = 47,
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  aobs_pkg::t_div_ctl   i_ctl,
    input  logic [BW-1:0]        i_rem,
    input  logic [BW-1:0]        i_div,
    input  logic [NW-1:0]        i_num,
    input  logic [NW-1:0]        i_quo,
    input  logic [PW-1:0]        i_pay,
    output aobs_pkg::t_div_ctl   o_ctl,
    output logic [BW-1:0]        o_rem,
    output logic [BW-1:0]        o_div,
    output logic [NW-1:0]        o_num,
    output logic [NW-1:0]        o_quo,
    output logic [PW-1:0]        o_pay
);

    aobs_pkg::t_div_ctl r_ctl;
    logic [BW-1:0]      r_rem, n_rem;
    logic [BW-1:0]      r_div;
    logic [NW-1:0]      r_num;
    logic [NW-1:0]      r_quo, n_quo;
    logic [PW-1:0]      r_pay;
    logic [BW:0]        w_trial;
    logic [BW:0]        w_diff;
    logic               w_ge;

    // One restoring step: bring down one numerator bit and try the divisor.
    always_comb begin
        w_trial = {i_rem, i_num[K]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[BW-1:0] : w_trial[BW-1:0];
        n_quo   = {i_quo[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_div <= i_div;
            r_num <= i_num;
            r_quo <= n_quo;
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_pay = r_pay;

endmodule

// ----- rtl/core/aobs_div_row.sv -----
module aobs_div_row #(
    parameter int FRAC_BITS = aobs_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32,
    parameter int PW        = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  aobs_pkg::t_fx        i_num,
    input  logic signed [DW-1:0] i_den,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output aobs_pkg::t_fx        o_quo,
    output logic [PW-1:0]        o_pay
);

    localparam int MW = aobs_pkg::MAGW;

    aobs_pkg::t_div_ctl s_ctl [0:MW];
    logic [DW-1:0]      s_rem [0:MW];
    logic [DW-1:0]      s_div [0:MW];
    logic [MW-1:0]      s_num [0:MW];
    logic [MW-1:0]      s_quo [0:MW];
    logic [PW-1:0]      s_pay [0:MW];

    aobs_pkg::t_mag     w_a;
    logic [DW-1:0]      w_b;
    logic [DW+MW-1:0]   w_bsh;
    logic [MW-1:0]      w_ash;

    // Operand setup: magnitudes, overflow test and the leading remainder.
    always_comb begin
        w_a   = aobs_pkg::mag_fx(i_num);
        w_b   = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        w_bsh = {{MW{1'b0}}, w_b} << (MW - FRAC_BITS);
        w_ash = w_a >> (MW - FRAC_BITS);
        s_ctl[0].valid = i_valid;
        s_ctl[0].neg   = i_num[aobs_pkg::FXW-1] ^ i_den[DW-1];
        s_ctl[0].ovf   = ({{DW{1'b0}}, w_a} >= w_bsh);
        s_rem[0] = w_ash[DW-1:0];
        s_div[0] = w_b;
        s_num[0] = w_a << FRAC_BITS;
        s_quo[0] = '0;
        s_pay[0] = i_pay;
    end

    // One cell per quotient bit, most significant first.
    for (genvar j = 0; j < MW; j++) begin : g_cell
        aobs_div_cell #(
            .BW (DW),
            .NW (MW),
            .K  (MW - 1 - j),
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctl   (s_ctl[j]),
            .i_rem   (s_rem[j]),
            .i_div   (s_div[j]),
            .i_num   (s_num[j]),
            .i_quo   (s_quo[j]),
            .i_pay   (s_pay[j]),
            .o_ctl   (s_ctl[j+1]),
            .o_rem   (s_rem[j+1]),
            .o_div   (s_div[j+1]),
            .o_num   (s_num[j+1]),
            .o_quo   (s_quo[j+1]),
            .o_pay   (s_pay[j+1])
        );
    end

    // Signed, saturated quotient.
    assign o_valid = s_ctl[MW].valid;
    assign o_quo   = aobs_pkg::from_mag(s_ctl[MW].ovf ? aobs_pkg::LIM : s_quo[MW],
                                        s_ctl[MW].neg);
    assign o_pay   = s_pay[MW];

endmodule

// ----- rtl/core/aobs_sqrt_cell.sv -----
module aobs_sqrt_cell #(
    parameter int NS = 32,
    parameter int P  = 0,
    parameter int PW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NS+1:0]     i_r,
    input  logic [NS-1:0]     i_q,
    input  logic [2*NS-1:0]   i_rad,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [NS+1:0]     o_r,
    output logic [NS-1:0]     o_q,
    output logic [2*NS-1:0]   o_rad,
    output logic [PW-1:0]     o_pay
);

    localparam int RQ = NS + 2;

    logic              r_valid;
    logic [RQ-1:0]     r_r, n_r;
    logic [NS-1:0]     r_q, n_q;
    logic [2*NS-1:0]   r_rad;
    logic [PW-1:0]     r_pay;
    logic [RQ+1:0]     w_trial;
    logic [RQ+1:0]     w_t;
    logic [RQ+1:0]     w_diff;
    logic              w_ge;

    // One digit step: bring down two radicand bits, try 4q+1.
    always_comb begin
        w_trial = {i_r, i_rad[2*P+1], i_rad[2*P]};
        w_t     = {2'b00, i_q, 2'b01};
        w_diff  = w_trial - w_t;
        w_ge    = (w_trial >= w_t);
        n_r     = w_ge ? w_diff[RQ-1:0] : w_trial[RQ-1:0];
        n_q     = {i_q[NS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= n_r;
            r_q   <= n_q;
            r_rad <= i_rad;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
    assign o_q     = r_q;
    assign o_rad   = r_rad;
    assign o_pay   = r_pay;

endmodule

// ----- rtl/core/aobs_sqrt_row.sv -----
module aobs_sqrt_row #(
    parameter int FRAC_BITS = aobs_pkg::FRAC_BITS_DEF,
    parameter int PW        = 1,
    parameter int NS        = (aobs_pkg::MAGW + FRAC_BITS + 1) / 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  aobs_pkg::t_fx   i_val,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [NS-1:0]   o_root,
    output logic [PW-1:0]   o_pay
);

    logic              s_valid [0:NS];
    logic [NS+1:0]     s_r     [0:NS];
    logic [NS-1:0]     s_q     [0:NS];
    logic [2*NS-1:0]   s_rad   [0:NS];
    logic [PW-1:0]     s_pay   [0:NS];

    // Radicand is the value scaled up by the fraction bits.
    always_comb begin
        s_valid[0] = i_valid;
        s_r[0]     = '0;
        s_q[0]     = '0;
        s_rad[0]   = (2*NS)'(aobs_pkg::mag_fx(i_val)) << FRAC_BITS;
        s_pay[0]   = i_pay;
    end

    // One cell per root bit, most significant first.
    for (genvar j = 0; j < NS; j++) begin : g_cell
        aobs_sqrt_cell #(
            .NS (NS),
            .P  (NS - 1 - j),
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (s_valid[j]),
            .i_r     (s_r[j]),
            .i_q     (s_q[j]),
            .i_rad   (s_rad[j]),
            .i_pay   (s_pay[j]),
            .o_valid (s_valid[j+1]),
            .o_r     (s_r[j+1]),
            .o_q     (s_q[j+1]),
            .o_rad   (s_rad[j+1]),
            .o_pay   (s_pay[j+1])
        );
    end

    assign o_valid = s_valid[NS];
    assign o_root  = s_q[NS];
    assign o_pay   = s_pay[NS];

endmodule

// ----- rtl/core/accel_or_brake_selector_core.sv -----
// Acceleration-or-brake selector for a two-phase motion profile.
// Input stream (i_s_*): one transfer carries current speed, target speed and
// remaining distance. Output stream (o_m_*): one transfer per input carries
// the chosen acceleration (accel or brake rate) and a status code.
// Configuration: i_cfg_we writes accel rate (index 0) or brake rate (index 1)
// from i_cfg_wdata; write only while the block holds no item in flight.
// Throughput: one item per cycle while the skid register is empty. The datapath
// is a chain of cells: three rows of 47 divider cells (the middle row doubled
// for both roots), one row of (48 + FRAC_BITS) / 2 square-root cells and eight
// arithmetic stages.
// Reset clears all valid bits and loads the default rates (+1.0 and -1.0).
// Output register plus a skid register: while a result waits on a stalled
// receiver the chain keeps moving until one more result reaches its end;
// that result goes to the skid register, o_s_tready drops and the whole
// chain holds its contents.
module accel_or_brake_selector_core #(
    parameter int FRAC_BITS = aobs_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [30:0] current_speed, [61:31] target_speed, [92:62] distance, rest zero
    input  logic [95:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] chosen_accel, [33:32] status, rest zero
    output logic [39:0]  o_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    localparam int MW  = aobs_pkg::MAGW;
    localparam int FW  = aobs_pkg::FXW;
    localparam int PPW = 2 * MW;
    localparam int NS  = (MW + FRAC_BITS + 1) / 2;
    localparam int EPS = ((1 << FRAC_BITS) + 500) / 1000;
    localparam aobs_pkg::t_fx EPS_FX = FW'(EPS);

    // Scaled product magnitude to a saturated signed value.
    function automatic aobs_pkg::t_fx prod_fx(input logic [PPW-1:0] p, input logic neg);
        logic [PPW-1:0] m;
        m = p >> FRAC_BITS;
        if (m > PPW'(aobs_pkg::LIM)) begin
            return aobs_pkg::from_mag(aobs_pkg::LIM, neg);
        end
        return aobs_pkg::from_mag(m[MW-1:0], neg);
    endfunction

    // Configuration registers.
    logic signed [31:0] r_accel;
    logic signed [31:0] r_brake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= aobs_pkg::ACCEL_RST;
            r_brake <= aobs_pkg::BRAKE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                aobs_pkg::CFG_ACCEL: r_accel <= i_cfg_wdata;
                aobs_pkg::CFG_BRAKE: r_brake <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Global advance: the chain moves unless the skid register is full.
    logic w_en;
    logic r_skid_v;
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    logic w_in_acc;
    assign w_in_acc = i_s_tvalid && w_en;

    logic signed [32:0] w_den;
    assign w_den = {r_brake[31], r_brake} - {r_accel[31], r_accel};

    // Ratio a1 / (a1 - a0), with the input fields riding alongside.
    logic          wa_valid;
    aobs_pkg::t_fx wa_r;
    logic [92:0]   wa_pay;

    aobs_div_row #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (33),
        .PW        (93)
    ) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_acc),
        .i_num   (FW'(r_brake)),
        .i_den   (w_den),
        .i_pay   (i_s_tdata[92:0]),
        .o_valid (wa_valid),
        .o_quo   (wa_r),
        .o_pay   (wa_pay)
    );

    // Stage 1: squares of the speeds and accel times distance.
    logic          r1_v;
    aobs_pkg::t_fx r1_r, r1_vv1, r1_vv0, r1_ad;
    logic [30:0]   r1_v0, r1_v1;
    logic [31:0]   w_a0m;

    assign w_a0m = r_accel[31] ? 32'(-r_accel) : 32'(r_accel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= wa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_r   <= wa_r;
            r1_vv1 <= prod_fx(PPW'(wa_pay[61:31]) * PPW'(wa_pay[61:31]), 1'b0);
            r1_vv0 <= prod_fx(PPW'(wa_pay[30:0]) * PPW'(wa_pay[30:0]), 1'b0);
            r1_ad  <= prod_fx(PPW'(w_a0m) * PPW'(wa_pay[92:62]), r_accel[31]);
            r1_v0  <= wa_pay[30:0];
            r1_v1  <= wa_pay[61:31];
        end
    end

    // Stage 2: q = (vv1 - vv0) - 2 * a0 * d.
    logic          r2_v;
    aobs_pkg::t_fx r2_r, r2_q, r2_vv1;
    logic [30:0]   r2_v0, r2_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_r   <= r1_r;
            r2_q   <= aobs_pkg::sub_fx(aobs_pkg::sub_fx(r1_vv1, r1_vv0),
                                       aobs_pkg::add_fx(r1_ad, r1_ad));
            r2_vv1 <= r1_vv1;
            r2_v0  <= r1_v0;
            r2_v1  <= r1_v1;
        end
    end

    // Stage 3: partial products of ratio times q.
    logic          r3_v, r3_neg;
    logic [63:0]   r3_p00;
    logic [46:0]   r3_p01, r3_p10;
    logic [29:0]   r3_p11;
    aobs_pkg::t_fx r3_vv1;
    logic [30:0]   r3_v0, r3_v1;
    aobs_pkg::t_mag w_rm, w_qm;

    assign w_rm = aobs_pkg::mag_fx(r2_r);
    assign w_qm = aobs_pkg::mag_fx(r2_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_p00 <= w_rm[31:0] * w_qm[31:0];
            r3_p01 <= w_rm[31:0] * w_qm[46:32];
            r3_p10 <= w_rm[46:32] * w_qm[31:0];
            r3_p11 <= w_rm[46:32] * w_qm[46:32];
            r3_neg <= r2_r[FW-1] ^ r2_q[FW-1];
            r3_vv1 <= r2_vv1;
            r3_v0  <= r2_v0;
            r3_v1  <= r2_v1;
        end
    end

    // Stage 4: sum the partial products.
    logic           r4_v, r4_neg;
    logic [PPW-1:0] r4_full;
    aobs_pkg::t_fx  r4_vv1;
    logic [30:0]    r4_v0, r4_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_full <= (PPW'(r3_p11) << 64) + (PPW'(r3_p01) << 32)
                     + (PPW'(r3_p10) << 32) + PPW'(r3_p00);
            r4_neg  <= r3_neg;
            r4_vv1  <= r3_vv1;
            r4_v0   <= r3_v0;
            r4_v1   <= r3_v1;
        end
    end

    // Stage 5: discriminant.
    logic          r5_v;
    aobs_pkg::t_fx r5_disc;
    logic [30:0]   r5_v0, r5_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_disc <= aobs_pkg::sub_fx(r4_vv1, prod_fx(r4_full, r4_neg));
            r5_v0   <= r4_v0;
            r5_v1   <= r4_v1;
        end
    end

    // Square root of the discriminant.
    logic          ws_valid;
    logic [NS-1:0] ws_root;
    logic [62:0]   ws_pay;

    aobs_sqrt_row #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (63),
        .NS        (NS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_val   (r5_disc),
        .i_pay   ({r5_disc[FW-1], r5_v1, r5_v0}),
        .o_valid (ws_valid),
        .o_root  (ws_root),
        .o_pay   (ws_pay)
    );

    // Stage 6: numerators of both roots.
    logic          r6_v, r6_nd;
    aobs_pkg::t_fx r6_sp, r6_sm;
    logic [30:0]   r6_v0, r6_v1;
    aobs_pkg::t_fx w_root_fx, w_v1_fx;

    assign w_root_fx = $signed(FW'(ws_root));
    assign w_v1_fx   = $signed(FW'(ws_pay[61:31]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= ws_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sp <= aobs_pkg::add_fx(w_v1_fx, w_root_fx);
            r6_sm <= aobs_pkg::sub_fx(w_v1_fx, w_root_fx);
            r6_nd <= ws_pay[62];
            r6_v0 <= ws_pay[30:0];
            r6_v1 <= ws_pay[61:31];
        end
    end

    // Both candidate brake times, divided in parallel rows.
    logic          wb_valid;
    aobs_pkg::t_fx wb_tp, wc_tm;
    logic [61:0]   wb_pay;
    logic          wc_pay;

    aobs_div_row #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (32),
        .PW        (62)
    ) u_div_plus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_num   (r6_sp),
        .i_den   (r_brake),
        .i_pay   ({r6_v1, r6_v0}),
        .o_valid (wb_valid),
        .o_quo   (wb_tp),
        .o_pay   (wb_pay)
    );

    aobs_div_row #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (32),
        .PW        (1)
    ) u_div_minus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_num   (r6_sm),
        .i_den   (r_brake),
        .i_pay   (r6_nd),
        .o_valid (),
        .o_quo   (wc_tm),
        .o_pay   (wc_pay)
    );

    // Stage 7: pick the brake time, start a1 * t1.
    logic          r7_v, r7_nd, r7_neg;
    logic [63:0]   r7_pl;
    logic [46:0]   r7_ph;
    aobs_pkg::t_fx r7_x;
    aobs_pkg::t_fx w_t1;
    aobs_pkg::t_mag w_t1m;
    logic [31:0]   w_a1m;

    always_comb begin
        if (wb_tp[FW-1]) begin
            w_t1 = wc_tm;
        end else if (wc_tm[FW-1]) begin
            w_t1 = wb_tp;
        end else begin
            w_t1 = (wb_tp < wc_tm) ? wb_tp : wc_tm;
        end
        w_t1m = aobs_pkg::mag_fx(w_t1);
        w_a1m = r_brake[31] ? 32'(-r_brake) : 32'(r_brake);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= wb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_pl  <= w_a1m * w_t1m[31:0];
            r7_ph  <= w_a1m * w_t1m[46:32];
            r7_neg <= r_brake[31] ^ w_t1[FW-1];
            r7_x   <= aobs_pkg::sub_fx($signed(FW'(wb_pay[61:31])),
                                       $signed(FW'(wb_pay[30:0])));
            r7_nd  <= wc_pay;
        end
    end

    // Stage 8: numerator of the accelerate-phase time.
    logic          r8_v, r8_nd;
    aobs_pkg::t_fx r8_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_num <= aobs_pkg::sub_fx(r7_x,
                          prod_fx((PPW'(r7_ph) << 32) + PPW'(r7_pl), r7_neg));
            r8_nd  <= r7_nd;
        end
    end

    // Accelerate-phase time.
    logic          wd_valid;
    aobs_pkg::t_fx wd_t0;
    logic          wd_nd;

    aobs_div_row #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (32),
        .PW        (1)
    ) u_div_t0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_v),
        .i_num   (r8_num),
        .i_den   (r_accel),
        .i_pay   (r8_nd),
        .o_valid (wd_valid),
        .o_quo   (wd_t0),
        .o_pay   (wd_nd)
    );

    // Decision and status.
    logic               w_zd;
    logic signed [31:0] w_chosen;
    logic [1:0]         w_status;

    always_comb begin
        w_zd = (w_den == '0) || (r_brake == '0) || (r_accel == '0);
        w_chosen = r_accel;
        w_status = aobs_pkg::ST_OK;
        if (w_zd) begin
            w_status = aobs_pkg::ST_ZERO_DIV;
        end else if (wd_nd) begin
            w_status = aobs_pkg::ST_NEG_DISC;
        end else if (wd_t0 < EPS_FX) begin
            w_chosen = r_brake;
        end
    end

    // Output register with skid register.
    logic               r_out_v;
    logic signed [31:0] r_out_acc, r_skid_acc;
    logic [1:0]         r_out_st, r_skid_st;
    logic               w_push, w_pop;

    assign w_push = w_en && wd_valid;
    assign w_pop  = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (w_pop) begin
                    r_skid_v <= 1'b0;
                end
            end else if (w_push) begin
                if (!r_out_v || w_pop) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out_acc <= r_skid_acc;
                r_out_st  <= r_skid_st;
            end
        end else if (w_push) begin
            if (!r_out_v || w_pop) begin
                r_out_acc <= w_chosen;
                r_out_st  <= w_status;
            end else begin
                r_skid_acc <= w_chosen;
                r_skid_st  <= w_status;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {6'b0, r_out_st, r_out_acc};

endmodule

// ----- verif/accel_or_brake_selector_core_tb.sv -----
module accel_or_brake_selector_core_tb;

    localparam int FRAC = aobs_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 3 * 47 + (48 + FRAC) / 2 + 9;
    localparam longint FX_LIM = (64'sd1 <<< 47) - 1;
    localparam longint EPS_FX = ((64'sd1 <<< FRAC) + 500) / 1000;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASES = 6;

    typedef struct packed {
        logic signed [31:0] accel;
        logic [1:0]         status;
    } t_choice;

    typedef struct {
        logic signed [31:0] accel;
        logic signed [31:0] brake;
        logic [30:0]        v0;
        logic [30:0]        v1;
        logic [30:0]        dst;
        bit                 known;
        logic signed [31:0] known_accel;
        logic [1:0]         known_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // [30:0] current_speed, [61:31] target_speed, [92:62] distance, rest zero
    logic [95:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // [31:0] chosen_accel, [33:32] status, rest zero
    logic [39:0] o_m_tdata;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    // Rates as the block currently holds them.
    logic signed [31:0] cur_accel;
    logic signed [31:0] cur_brake;

    t_choice pending_choices[$];
    int      mismatches;
    int      results_seen;
    int      items_sent;
    int      ok_count, neg_disc_count, zero_div_count, brake_count;
    int      cycles;
    bit      long_hold_done;

    accel_or_brake_selector_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Fixed-point helpers on a 64-bit container saturated to +/-(2^47 - 1).
    function automatic longint clamp_fx(input longint v);
        if (v > FX_LIM) return FX_LIM;
        if (v < -FX_LIM) return -FX_LIM;
        return v;
    endfunction

    function automatic longint signed_mag(input logic [127:0] m, input bit neg);
        longint r;
        if (m > 128'(FX_LIM)) m = 128'(FX_LIM);
        r = longint'(m[63:0]);
        return neg ? -r : r;
    endfunction

    function automatic logic [127:0] abs_fx(input longint v);
        return 128'(v < 0 ? -v : v);
    endfunction

    function automatic longint mul_fx(input longint x, input longint y);
        logic [127:0] p;
        p = (abs_fx(x) * abs_fx(y)) >> FRAC;
        return signed_mag(p, (x < 0) != (y < 0));
    endfunction

    function automatic longint div_fx(input longint x, input longint y);
        logic [127:0] q;
        q = (abs_fx(x) << FRAC) / abs_fx(y);
        return signed_mag(q, (x < 0) != (y < 0));
    endfunction

    function automatic longint sqrt_fx(input longint x);
        logic [127:0] n, root, trial;
        n = abs_fx(x) << FRAC;
        root = 0;
        for (int i = 40; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (trial * trial <= n) root = trial;
        end
        return longint'(root[63:0]);
    endfunction

    // Predicted acceleration choice for one set of motion operands.
    function automatic t_choice choose_accel(input logic [30:0] v0_in,
                                             input logic [30:0] v1_in,
                                             input logic [30:0] dst_in);
        longint a0, a1, v0, v1, dst;
        longint vv0, vv1, ad, q, disc, root, tp, tm, t1, t0;
        t_choice c;
        a0 = longint'(cur_accel);
        a1 = longint'(cur_brake);
        v0 = longint'({33'd0, v0_in});
        v1 = longint'({33'd0, v1_in});
        dst = longint'({33'd0, dst_in});
        c.accel = cur_accel;
        c.status = aobs_pkg::ST_OK;
        if (a1 - a0 == 0 || a1 == 0 || a0 == 0) begin
            c.status = aobs_pkg::ST_ZERO_DIV;
            return c;
        end
        vv1 = mul_fx(v1, v1);
        vv0 = mul_fx(v0, v0);
        ad = mul_fx(a0, dst);
        q = clamp_fx(clamp_fx(vv1 - vv0) - clamp_fx(ad + ad));
        disc = clamp_fx(vv1 - mul_fx(div_fx(a1, a1 - a0), q));
        if (disc < 0) begin
            c.status = aobs_pkg::ST_NEG_DISC;
            return c;
        end
        root = sqrt_fx(disc);
        tp = div_fx(clamp_fx(v1 + root), a1);
        tm = div_fx(clamp_fx(v1 - root), a1);
        // Take the smaller root unless one of them is negative.
        if (tp < 0) t1 = tm;
        else if (tm < 0) t1 = tp;
        else t1 = (tp < tm) ? tp : tm;
        t0 = div_fx(clamp_fx(clamp_fx(v1 - v0) - mul_fx(a1, t1)), a0);
        if (t0 < EPS_FX) c.accel = cur_brake;
        return c;
    endfunction

    // Random operand with a random magnitude so small and large values both occur.
    function automatic logic [30:0] rand_operand();
        int w;
        w = $urandom_range(0, 31);
        return 31'($urandom) & 31'((64'd1 << w) - 1);
    endfunction

    // Timeout.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycles, pending_choices.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result checker: each output transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_choice want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_choices.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected result %h at cycle %0d", o_m_tdata, cycles);
            end else begin
                want = pending_choices.pop_front();
                if (o_m_tdata[31:0] !== want.accel || o_m_tdata[33:32] !== want.status
                        || o_m_tdata[39:34] !== 6'd0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch at cycle %0d: accel exp %h got %h, status exp %0d got %0d",
                                 cycles, want.accel, o_m_tdata[31:0], want.status,
                                 o_m_tdata[33:32]);
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to fill the pipeline.
    initial begin
        int hold;
        i_m_tready = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && items_sent >= 600) begin
                long_hold_done = 1'b1;
                hold = 3 * LATENCY;
                i_m_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            case ($urandom_range(0, 19))
                0, 1, 2: i_m_tready <= 1'b0;
                3: begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(5, 40)) @(negedge i_clk);
                end
                default: i_m_tready <= 1'b1;
            endcase
        end
    end

    task automatic wait_idle();
        while (pending_choices.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write; caller is on a falling edge with the block idle.
    task automatic write_rates(input logic signed [31:0] accel,
                               input logic signed [31:0] brake);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= aobs_pkg::CFG_ACCEL;
        i_cfg_wdata <= accel;
        @(negedge i_clk);
        i_cfg_addr <= aobs_pkg::CFG_BRAKE;
        i_cfg_wdata <= brake;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_accel = accel;
        cur_brake = brake;
    endtask

    // One input transfer; called on a falling edge. An optional gap follows.
    task automatic send_operands(input logic [30:0] v0, input logic [30:0] v1,
                                 input logic [30:0] dst, input bit known,
                                 input t_choice known_choice, input bit idle_ok);
        t_choice pred;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'd0, dst, v1, v0};
        do @(posedge i_clk); while (!o_s_tready);
        pred = choose_accel(v0, v1, dst);
        if (known && pred !== known_choice)
            $display("Note: typed expectation %h differs from prediction %h",
                     known_choice, pred);
        pending_choices.push_back(known ? known_choice : pred);
        items_sent++;
        case (pred.status)
            aobs_pkg::ST_OK:       ok_count++;
            aobs_pkg::ST_NEG_DISC: neg_disc_count++;
            default:               zero_div_count++;
        endcase
        if (pred.status == aobs_pkg::ST_OK && pred.accel == cur_brake) brake_count++;
        @(negedge i_clk);
        if (idle_ok) begin
            case ($urandom_range(0, 15))
                0, 1, 2: begin
                    i_s_tvalid <= 1'b0;
                    @(negedge i_clk);
                end
                3: begin
                    i_s_tvalid <= 1'b0;
                    repeat ($urandom_range(3, 30)) @(negedge i_clk);
                end
                default: ;
            endcase
        end
    endtask

    // Directed operands: extremes, every status and both choices.
    t_row directed_rows[] = '{
        '{32'sh0001_0000, -32'sh0001_0000, 31'd0, 31'd0, 31'd0, 0, 0, aobs_pkg::ST_OK},
        '{32'sh0001_0000, -32'sh0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
          0, 0, aobs_pkg::ST_OK},
        '{32'sh0001_0000, -32'sh0001_0000, 31'h0005_0000, 31'd0, 31'h0001_0000,
          0, 0, aobs_pkg::ST_OK},
        '{32'sh0001_0000, -32'sh0001_0000, 31'd0, 31'd0, 31'h7FFF_FFFF,
          0, 0, aobs_pkg::ST_OK},
        '{32'sh0001_0000, -32'sh0001_0000, 31'h7FFF_FFFF, 31'd0, 31'd0,
          0, 0, aobs_pkg::ST_OK},
        '{32'sh0001_0000, -32'sh0001_0000, 31'h5555_5555, 31'h2AAA_AAAA, 31'h1234_5678,
          0, 0, aobs_pkg::ST_OK},
        // Zero divisor: accel rate is zero.
        '{32'sh0000_0000, -32'sh0001_0000, 31'h0001_0000, 31'd0, 31'h0001_0000,
          1, 32'sh0000_0000, aobs_pkg::ST_ZERO_DIV},
        // Zero divisor: brake rate is zero.
        '{32'sh0001_0000, 32'sh0000_0000, 31'h0001_0000, 31'd0, 31'h0001_0000,
          1, 32'sh0001_0000, aobs_pkg::ST_ZERO_DIV},
        // Zero divisor: both rates equal.
        '{32'sh0002_0000, 32'sh0002_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
          1, 32'sh0002_0000, aobs_pkg::ST_ZERO_DIV},
        // Negative discriminant with both rates positive.
        '{32'sh0001_0000, 32'sh0002_0000, 31'd0, 31'h0001_0000, 31'd0,
          1, 32'sh0001_0000, aobs_pkg::ST_NEG_DISC},
        '{32'sh0001_0000, 32'sh0002_0000, 31'h0003_0000, 31'h0001_0000, 31'd5,
          0, 0, aobs_pkg::ST_OK},
        // Register extremes.
        '{32'sh7FFF_FFFF, -32'sh8000_0000, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF,
          0, 0, aobs_pkg::ST_OK},
        '{32'sh7FFF_FFFF, -32'sh8000_0000, 31'd1, 31'h7FFF_FFFF, 31'd1,
          0, 0, aobs_pkg::ST_OK},
        '{-32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0010_0000, 31'h0002_0000, 31'h0100_0000,
          0, 0, aobs_pkg::ST_OK},
        '{32'sh0000_0001, -32'sh0000_0001, 31'h0000_8000, 31'h0000_4000, 31'h0000_0100,
          0, 0, aobs_pkg::ST_OK}
    };

    // Stimulus.
    initial begin
        logic signed [31:0] ra, rb;
        t_choice typed;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = aobs_pkg::CFG_ACCEL;
        i_cfg_wdata = '0;
        cur_accel = aobs_pkg::ACCEL_RST;
        cur_brake = aobs_pkg::BRAKE_RST;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        ok_count = 0;
        neg_disc_count = 0;
        zero_div_count = 0;
        brake_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table; the first row runs with the reset rates.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].accel !== cur_accel || directed_rows[k].brake !== cur_brake) begin
                i_s_tvalid <= 1'b0;
                wait_idle();
                write_rates(directed_rows[k].accel, directed_rows[k].brake);
            end
            typed.accel = directed_rows[k].known_accel;
            typed.status = directed_rows[k].known_status;
            send_operands(directed_rows[k].v0, directed_rows[k].v1, directed_rows[k].dst,
                          directed_rows[k].known, typed, 1'b1);
        end

        // Random phases, each with its own rates.
        for (int ph = 0; ph < PHASES; ph++) begin
            i_s_tvalid <= 1'b0;
            wait_idle();
            case (ph)
                0: begin ra = aobs_pkg::ACCEL_RST; rb = aobs_pkg::BRAKE_RST; end
                1: begin ra = 32'sh7FFF_FFFF; rb = -32'sh8000_0000; end
                2: begin ra = 32'sh0000_0100; rb = -32'sh0000_0100; end
                3: begin ra = 32'sh0000_4000; rb = 32'sh0000_4000; end
                default: begin
                    ra = 32'($urandom_range(1, 32'h0040_0000));
                    rb = -32'($urandom_range(1, 32'h0040_0000));
                end
            endcase
            write_rates(ra, rb);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                // A stretch without gaps every now and then.
                send_operands(rand_operand(), rand_operand(), rand_operand(), 1'b0,
                              '0, (n % 100) >= 30);
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain.
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (o_m_tvalid) begin
            mismatches++;
            $display("Output still valid after drain");
        end
        $display("Sent %0d items: %0d ok (%0d braking), %0d negative discriminant, %0d zero divisor",
                 items_sent, ok_count, brake_count, neg_disc_count, zero_div_count);
        $display("Checked %0d results from the directed table and %0d random phases, %0d mismatches",
                 results_seen, PHASES, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
